@@ hdl/spq_pkg.sv @@
// Shared constants, types and operation codes of the sorted priority queue.
package spq_pkg;

	localparam int QueueDepth    = 16;
	localparam int PriorityWidth = 16;
	localparam int DataWidth     = 32;
	localparam int CountWidth    = $clog2(QueueDepth + 1);

	localparam logic [2:0] OP_INSERT     = 3'd0;
	localparam logic [2:0] OP_REMOVE     = 3'd1;
	localparam logic [2:0] OP_PEEK_FRONT = 3'd2;
	localparam logic [2:0] OP_PEEK_TAIL  = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;

	typedef logic [1:0] cell_cmd_t;
	localparam cell_cmd_t CMD_HOLD   = 2'd0;
	localparam cell_cmd_t CMD_INSERT = 2'd1;
	localparam cell_cmd_t CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [PriorityWidth-1:0] prio;
		logic [DataWidth-1:0]     data;
	} entry_t;

	typedef struct packed {
		cell_cmd_t cmd;
		entry_t    new_entry;
	} cell_ctrl_t;

endpackage

@@ hdl/spq_cell.sv @@
// One slot of the queue: holds an entry and shifts it toward either neighbor.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               left_keep,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               keep
);

	spq_pkg::entry_t entry_q;

	// An occupied slot whose priority is at least the new one stays in place on insert.
	assign keep  = occupied && (entry_q.prio >= ctrl.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			spq_pkg::CMD_INSERT: begin
				if (!keep) begin
					entry_q <= left_keep ? ctrl.new_entry : left_entry;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

@@ hdl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: decoder, count, chain of slots and result register.
//
// The input channel takes one word per operation: opcode, item_priority and
// item_data. Every accepted word yields exactly one result word on the output
// channel: status, out_priority, out_data, entry_count and is_empty.
// The result appears in the cycle after the word is accepted, and one word can
// be accepted in every cycle in which in_stall is low, so the throughput is
// one operation per clock while no stall is raised. All slots compare against
// a new priority in parallel and shift by one position in the same cycle.
// Reset clears the entry count and the output valid flag; slot contents are
// left as they are and only occupied slots are ever read out as results.
// While the receiver stalls a pending result, in_stall is raised and no new
// word is accepted; the result is held until it is taken.
// Equal priorities leave in the order they were inserted. Insert on a full
// queue and remove, peek or clear on an empty queue report a failure and
// leave the queue unchanged.
module sorted_priority_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         opcode,
	input  logic [spq_pkg::PriorityWidth-1:0]  item_priority,
	input  logic [spq_pkg::DataWidth-1:0]      item_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               status,
	output logic [spq_pkg::PriorityWidth-1:0]  out_priority,
	output logic [spq_pkg::DataWidth-1:0]      out_data,
	output logic [spq_pkg::CountWidth-1:0]     entry_count,
	output logic                               is_empty
);

	localparam int Depth = spq_pkg::QueueDepth;
	localparam int CW    = spq_pkg::CountWidth;

	logic                      accept;
	logic                      out_valid_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_next;
	logic                      full;
	logic                      empty;
	logic                      fail;
	spq_pkg::cell_cmd_t        cmd;
	spq_pkg::cell_ctrl_t       ctrl;
	spq_pkg::entry_t           result;
	spq_pkg::entry_t           tail_entry;
	spq_pkg::entry_t           entries [Depth];
	logic [Depth-1:0]          keeps;
	logic [Depth-1:0]          occupied;

	logic                               status_q;
	logic [spq_pkg::PriorityWidth-1:0]  out_priority_q;
	logic [spq_pkg::DataWidth-1:0]      out_data_q;
	logic [CW-1:0]                      entry_count_q;
	logic                               is_empty_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(Depth));
	assign empty    = (count_q == '0);

	always_comb begin
		tail_entry = '0;
		for (int i = 0; i < Depth; i++) begin
			if (count_q == CW'(i + 1)) begin
				tail_entry = entries[i];
			end
		end
	end

	always_comb begin
		cmd        = spq_pkg::CMD_HOLD;
		count_next = count_q;
		fail       = 1'b1;
		result     = '0;
		unique case (opcode)
			spq_pkg::OP_INSERT: begin
				if (!full) begin
					cmd        = spq_pkg::CMD_INSERT;
					count_next = count_q + CW'(1);
					fail       = 1'b0;
				end
			end
			spq_pkg::OP_REMOVE: begin
				if (!empty) begin
					cmd        = spq_pkg::CMD_REMOVE;
					count_next = count_q - CW'(1);
					fail       = 1'b0;
					result     = entries[0];
				end
			end
			spq_pkg::OP_PEEK_FRONT: begin
				if (!empty) begin
					fail   = 1'b0;
					result = entries[0];
				end
			end
			spq_pkg::OP_PEEK_TAIL: begin
				if (!empty) begin
					fail   = 1'b0;
					result = tail_entry;
				end
			end
			spq_pkg::OP_CLEAR: begin
				if (!empty) begin
					count_next = '0;
					fail       = 1'b0;
				end
			end
			default: begin
				fail = 1'b1;
			end
		endcase
	end

	assign ctrl.cmd            = accept ? cmd : spq_pkg::CMD_HOLD;
	assign ctrl.new_entry.prio = item_priority;
	assign ctrl.new_entry.data = item_data;

	for (genvar i = 0; i < Depth; i++) begin : g_cell
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;
		logic            left_keep;

		assign occupied[i] = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_entry = ctrl.new_entry;
			assign left_keep  = 1'b1;
		end else begin : g_inner
			assign left_entry = entries[i-1];
			assign left_keep  = keeps[i-1];
		end

		if (i == Depth - 1) begin : g_last
			assign right_entry = entries[i];
		end else begin : g_body
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occupied[i]),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.keep        (keeps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= fail;
			out_priority_q <= result.prio;
			out_data_q     <= result.data;
			entry_count_q  <= count_next;
			is_empty_q     <= (count_next == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = out_priority_q;
	assign out_data     = out_data_q;
	assign entry_count  = entry_count_q;
	assign is_empty     = is_empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("entry count exceeds queue depth");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (entries[0].prio >= entries[1].prio))
		else $error("front slots are out of priority order");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == spq_pkg::OP_REMOVE && !empty)
		|=> (count_q == CW'($past(count_q) - CW'(1))))
		else $error("remove did not decrement the entry count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_valid_q && entry_count_q == count_q))
		else $error("result count does not match the queue count");

endmodule
